// ----- src/tdpa_pkg.sv -----
// Shared types and constants for the tree depth block (parent table walker).
// No dependencies; every other file imports this package.
package tdpa_pkg;

    // Table size and field widths
    localparam int MAX_CELLS = 1024;
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int CNT_W     = CELL_W + 1;
    localparam int ENTRY_W   = CELL_W + 1;

    // Configuration port
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam logic [ADDR_W-1:0] ADDR_CELL_COUNT = 3'd0;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_CELL  = 2'd1,
        REQ_MAX   = 2'd2
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_CYCLE = 2'd2
    } status_t;

    // Shared unit operations
    typedef enum logic {
        ALU_INC = 1'b0,
        ALU_DEC = 1'b1
    } alu_op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RC_CLR,
        S_RC_RD,
        S_RC_CHK,
        S_RC_INC,
        S_RC_NEXT,
        S_WR_OLD,
        S_WR_DEC,
        S_WR_INC_RD,
        S_WR_INC,
        S_WALK,
        S_DONE
    } state_t;

    // One memory's access for a cycle
    typedef struct packed {
        logic [CELL_W-1:0]  rd_addr;
        logic               wr_en;
        logic [CELL_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
    } mem_req_t;

    // Shared unit request and response
    typedef struct packed {
        alu_op_t            op;
        logic [CNT_W-1:0]   operand;
        logic [CNT_W-1:0]   limit;
    } alu_req_t;

    typedef struct packed {
        logic [CNT_W-1:0]   result;
        logic               zero;
        logic               lt;
    } alu_rsp_t;

endpackage

// ----- src/tdpa_store.sv -----
// Parent table and child count memories, one write and one registered read each.
// Depends on tdpa_pkg for widths and the memory access struct.
module tdpa_store (
    input  logic                          aclk,
    input  tdpa_pkg::mem_req_t            p_req,
    input  tdpa_pkg::mem_req_t            c_req,
    output logic [tdpa_pkg::ENTRY_W-1:0]  p_rd_data,
    output logic [tdpa_pkg::ENTRY_W-1:0]  c_rd_data
);
    import tdpa_pkg::*;

    logic [ENTRY_W-1:0] parent_mem [MAX_CELLS];
    logic [ENTRY_W-1:0] child_mem  [MAX_CELLS];
    logic [ENTRY_W-1:0] p_rd_data_reg;
    logic [ENTRY_W-1:0] c_rd_data_reg;

    // Parent table: write port and registered read
    always_ff @(posedge aclk) begin
        if (p_req.wr_en) begin
            parent_mem[p_req.wr_addr] <= p_req.wr_data;
        end
        p_rd_data_reg <= parent_mem[p_req.rd_addr];
    end

    // Child counts: write port and registered read
    always_ff @(posedge aclk) begin
        if (c_req.wr_en) begin
            child_mem[c_req.wr_addr] <= c_req.wr_data;
        end
        c_rd_data_reg <= child_mem[c_req.rd_addr];
    end

    assign p_rd_data = p_rd_data_reg;
    assign c_rd_data = c_rd_data_reg;

endmodule

// ----- src/tdpa_alu.sv -----
// Shared increment/decrement unit with limit compare, used by every sequence.
// Depends on tdpa_pkg for the request and response structs.
module tdpa_alu (
    input  tdpa_pkg::alu_req_t alu_req,
    output tdpa_pkg::alu_rsp_t alu_rsp
);
    import tdpa_pkg::*;

    logic [CNT_W-1:0] sum;

    // Step the operand by one
    always_comb begin
        unique case (alu_req.op)
            ALU_INC: sum = alu_req.operand + CNT_W'(1);
            ALU_DEC: sum = alu_req.operand - CNT_W'(1);
            default: sum = alu_req.operand;
        endcase
    end

    // Report result, zero operand and result below limit
    assign alu_rsp.result = sum;
    assign alu_rsp.zero   = (alu_req.operand == '0);
    assign alu_rsp.lt     = (sum < alu_req.limit);

endmodule

// ----- src/tdpa_ctrl.sv -----
// Sequencer: clear pass, child recount, entry writes, parent walks, result register.
// Depends on tdpa_pkg; drives tdpa_store and tdpa_alu through structs.
module tdpa_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tdpa_pkg::CNT_W-1:0]    n,
    input  logic                          cfg_wr,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [tdpa_pkg::CELL_W-1:0]   s_cell_index,
    input  logic                          s_has_parent,
    input  logic [tdpa_pkg::CELL_W-1:0]   s_parent_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tdpa_pkg::CELL_W-1:0]   m_depth,
    output logic                          m_is_leaf,
    output logic [tdpa_pkg::CELL_W-1:0]   m_max_depth,
    output logic [1:0]                    m_status,
    output tdpa_pkg::mem_req_t            p_req,
    output tdpa_pkg::mem_req_t            c_req,
    input  logic [tdpa_pkg::ENTRY_W-1:0]  p_rd_data,
    input  logic [tdpa_pkg::ENTRY_W-1:0]  c_rd_data,
    output tdpa_pkg::alu_req_t            alu_req,
    input  tdpa_pkg::alu_rsp_t            alu_rsp
);
    import tdpa_pkg::*;

    state_t              state_reg, state_next;
    logic [CELL_W-1:0]   idx_reg, idx_next;
    logic [CELL_W-1:0]   cell_reg, cell_next;
    logic [CELL_W-1:0]   par_reg, par_next;
    logic                hasp_reg, hasp_next;
    logic [CELL_W-1:0]   op_reg, op_next;
    logic [CNT_W-1:0]    d_reg, d_next;
    logic [CELL_W-1:0]   maxd_reg, maxd_next;
    logic                max_mode_reg, max_mode_next;

    logic [CELL_W-1:0]   res_depth_reg, res_depth_next;
    logic                res_leaf_reg, res_leaf_next;
    logic [CELL_W-1:0]   res_maxd_reg, res_maxd_next;
    status_t             res_status_reg, res_status_next;

    logic                m_valid_reg, m_valid_next;
    logic [CELL_W-1:0]   m_depth_reg, m_depth_next;
    logic                m_is_leaf_reg, m_is_leaf_next;
    logic [CELL_W-1:0]   m_max_depth_reg, m_max_depth_next;
    status_t             m_status_reg, m_status_next;

    logic                s_fire;
    logic                n_zero;
    logic                in_cell_ok;
    logic                in_par_ok;
    logic                e_hasp;
    logic [CELL_W-1:0]   e_par;
    logic                e_par_ok;
    logic                out_free;
    logic [CELL_W-1:0]   new_max;

    // Decode conditions shared by both control blocks
    assign s_ready    = (state_reg == S_IDLE) && !cfg_wr;
    assign s_fire     = s_valid && s_ready;
    assign n_zero     = (n == '0);
    assign in_cell_ok = ({1'b0, s_cell_index} < n);
    assign in_par_ok  = ({1'b0, s_parent_index} < n);
    assign e_hasp     = p_rd_data[ENTRY_W-1];
    assign e_par      = p_rd_data[CELL_W-1:0];
    assign e_par_ok   = ({1'b0, e_par} < n);
    assign out_free   = !m_valid_reg || m_ready;
    assign new_max    = (d_reg[CELL_W-1:0] > maxd_reg) ? d_reg[CELL_W-1:0] : maxd_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (!alu_rsp.lt) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_req_type)
                        REQ_WRITE: state_next = (in_cell_ok && (!s_has_parent || in_par_ok))
                                                ? S_WR_OLD : S_DONE;
                        REQ_CELL:  state_next = in_cell_ok ? S_WALK : S_DONE;
                        REQ_MAX:   state_next = n_zero ? S_DONE : S_WALK;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_RC_CLR: begin
                if (n_zero) state_next = S_IDLE;
                else if (!alu_rsp.lt) state_next = S_RC_RD;
            end
            S_RC_RD:     state_next = S_RC_CHK;
            S_RC_CHK:    state_next = (e_hasp && e_par_ok) ? S_RC_INC : S_RC_NEXT;
            S_RC_INC:    state_next = S_RC_NEXT;
            S_RC_NEXT:   state_next = alu_rsp.lt ? S_RC_RD : S_IDLE;
            S_WR_OLD: begin
                if (e_hasp && e_par_ok) state_next = S_WR_DEC;
                else state_next = hasp_reg ? S_WR_INC_RD : S_DONE;
            end
            S_WR_DEC:    state_next = hasp_reg ? S_WR_INC_RD : S_DONE;
            S_WR_INC_RD: state_next = S_WR_INC;
            S_WR_INC:    state_next = S_DONE;
            S_WALK: begin
                if (!e_hasp) begin
                    if (!max_mode_reg || !alu_rsp.lt) state_next = S_DONE;
                end else if (!e_par_ok || !alu_rsp.lt) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
        // A cell count write restarts the child recount
        if (cfg_wr && state_reg != S_CLEAR) state_next = S_RC_CLR;
    end

    // Datapath control, memory accesses and result capture
    always_comb begin
        p_req = '{rd_addr: cell_reg, wr_en: 1'b0, wr_addr: cell_reg, wr_data: '0};
        c_req = '{rd_addr: cell_reg, wr_en: 1'b0, wr_addr: idx_reg, wr_data: '0};
        alu_req = '{op: ALU_INC, operand: {1'b0, idx_reg}, limit: n};

        idx_next      = idx_reg;
        cell_next     = cell_reg;
        par_next      = par_reg;
        hasp_next     = hasp_reg;
        op_next       = op_reg;
        d_next        = d_reg;
        maxd_next     = maxd_reg;
        max_mode_next = max_mode_reg;

        res_depth_next  = res_depth_reg;
        res_leaf_next   = res_leaf_reg;
        res_maxd_next   = res_maxd_reg;
        res_status_next = res_status_reg;

        m_valid_next     = m_valid_reg && !m_ready;
        m_depth_next     = m_depth_reg;
        m_is_leaf_next   = m_is_leaf_reg;
        m_max_depth_next = m_max_depth_reg;
        m_status_next    = m_status_reg;

        unique case (state_reg)
            S_CLEAR: begin
                // Sweep both tables to zero after reset
                p_req.wr_en   = 1'b1;
                p_req.wr_addr = idx_reg;
                c_req.wr_en   = 1'b1;
                c_req.wr_addr = idx_reg;
                alu_req.limit = CNT_W'(MAX_CELLS);
                idx_next      = alu_rsp.result[CELL_W-1:0];
            end
            S_IDLE: begin
                p_req.rd_addr = s_cell_index;
                c_req.rd_addr = s_cell_index;
                if (s_req_type == REQ_MAX) p_req.rd_addr = '0;
                if (s_fire) begin
                    cell_next       = s_cell_index;
                    par_next        = s_parent_index;
                    hasp_next       = s_has_parent;
                    d_next          = '0;
                    maxd_next       = '0;
                    idx_next        = '0;
                    max_mode_next   = (s_req_type == REQ_MAX);
                    res_depth_next  = '0;
                    res_leaf_next   = 1'b0;
                    res_maxd_next   = '0;
                    res_status_next = ST_OK;
                    unique case (s_req_type)
                        REQ_WRITE: begin
                            if (!in_cell_ok || (s_has_parent && !in_par_ok))
                                res_status_next = ST_RANGE;
                        end
                        REQ_CELL: begin
                            if (!in_cell_ok) res_status_next = ST_RANGE;
                        end
                        REQ_MAX:  res_status_next = ST_OK;
                        default:  res_status_next = ST_RANGE;
                    endcase
                end
            end
            S_RC_CLR: begin
                // Zero the counts of the cells in use
                if (!n_zero) begin
                    c_req.wr_en   = 1'b1;
                    c_req.wr_addr = idx_reg;
                    idx_next      = alu_rsp.lt ? alu_rsp.result[CELL_W-1:0] : '0;
                end
            end
            S_RC_RD: begin
                p_req.rd_addr = idx_reg;
            end
            S_RC_CHK: begin
                c_req.rd_addr = e_par;
                op_next       = e_par;
            end
            S_RC_INC: begin
                alu_req.operand = c_rd_data;
                c_req.wr_en     = 1'b1;
                c_req.wr_addr   = op_reg;
                c_req.wr_data   = alu_rsp.result;
            end
            S_RC_NEXT: begin
                idx_next = alu_rsp.lt ? alu_rsp.result[CELL_W-1:0] : '0;
            end
            S_WR_OLD: begin
                // Store the new entry, fetch the old parent's count
                p_req.wr_en   = 1'b1;
                p_req.wr_addr = cell_reg;
                p_req.wr_data = hasp_reg ? {1'b1, par_reg} : '0;
                c_req.rd_addr = e_par;
                op_next       = e_par;
            end
            S_WR_DEC: begin
                alu_req.op      = ALU_DEC;
                alu_req.operand = c_rd_data;
                c_req.wr_en     = !alu_rsp.zero;
                c_req.wr_addr   = op_reg;
                c_req.wr_data   = alu_rsp.result;
            end
            S_WR_INC_RD: begin
                c_req.rd_addr = par_reg;
            end
            S_WR_INC: begin
                alu_req.operand = c_rd_data;
                c_req.wr_en     = 1'b1;
                c_req.wr_addr   = par_reg;
                c_req.wr_data   = alu_rsp.result;
            end
            S_WALK: begin
                if (!e_hasp) begin
                    // Reached a root
                    if (max_mode_reg) begin
                        if (alu_rsp.lt) begin
                            maxd_next     = new_max;
                            idx_next      = alu_rsp.result[CELL_W-1:0];
                            d_next        = '0;
                            p_req.rd_addr = alu_rsp.result[CELL_W-1:0];
                        end else begin
                            res_maxd_next = new_max;
                        end
                    end else begin
                        res_depth_next = d_reg[CELL_W-1:0];
                        res_leaf_next  = (c_rd_data == '0);
                    end
                end else if (!e_par_ok) begin
                    res_status_next = ST_RANGE;
                end else begin
                    // Climb one level
                    alu_req.operand = d_reg;
                    if (alu_rsp.lt) begin
                        d_next        = alu_rsp.result;
                        p_req.rd_addr = e_par;
                    end else begin
                        res_status_next = ST_CYCLE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_depth_next     = res_depth_reg;
                    m_is_leaf_next   = res_leaf_reg;
                    m_max_depth_next = res_maxd_reg;
                    m_status_next    = res_status_reg;
                end
            end
            default: ;
        endcase

        if (cfg_wr && state_reg != S_CLEAR) idx_next = '0;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cell_reg        <= cell_next;
        par_reg         <= par_next;
        hasp_reg        <= hasp_next;
        op_reg          <= op_next;
        d_reg           <= d_next;
        maxd_reg        <= maxd_next;
        max_mode_reg    <= max_mode_next;
        res_depth_reg   <= res_depth_next;
        res_leaf_reg    <= res_leaf_next;
        res_maxd_reg    <= res_maxd_next;
        res_status_reg  <= res_status_next;
        m_depth_reg     <= m_depth_next;
        m_is_leaf_reg   <= m_is_leaf_next;
        m_max_depth_reg <= m_max_depth_next;
        m_status_reg    <= m_status_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_depth     = m_depth_reg;
    assign m_is_leaf   = m_is_leaf_reg;
    assign m_max_depth = m_max_depth_reg;
    assign m_status    = m_status_reg;

    // Walks and idle cycles leave both tables untouched
    a_no_write_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK || state_reg == S_IDLE) |-> (!p_req.wr_en && !c_req.wr_en))
        else $error("table written during walk or idle");

    // The level count stays below the cells in use
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (d_reg < n))
        else $error("walk depth reached cell count");

    // A failed request reports zero fields
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK)
        |-> (m_depth_reg == '0 && m_max_depth_reg == '0 && !m_is_leaf_reg))
        else $error("error result carries nonzero fields");

    // A finished result waits while the output beat is stalled
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid_reg && !m_ready && !cfg_wr) |=> (state_reg == S_DONE))
        else $error("result left while output stalled");

endmodule

// ----- src/tree_depth_from_parent_array_top.sv -----
// Throughput: one request at a time; the next beat is taken once the result is registered.
// The walk costs one parent table read per level through a single shared step unit.
// Reset: synchronous, active low; a clearing pass over all 1024 table entries follows, input not ready.
// A cell_count write starts a recount over the cells in use, input not ready.
// Top level: APB cell_count register, parent/child tables, shared unit, sequencer.
module tree_depth_from_parent_array_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tdpa_pkg::ADDR_W-1:0]   paddr,
    input  logic [tdpa_pkg::DATA_W-1:0]   pwdata,
    output logic [tdpa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [tdpa_pkg::CELL_W-1:0]   s_cell_index,
    input  logic                          s_has_parent,
    input  logic [tdpa_pkg::CELL_W-1:0]   s_parent_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tdpa_pkg::CELL_W-1:0]   m_depth,
    output logic                          m_is_leaf,
    output logic [tdpa_pkg::CELL_W-1:0]   m_max_depth,
    output logic [1:0]                    m_status
);
    import tdpa_pkg::*;

    logic [CNT_W-1:0]   cell_count_reg;
    logic [CNT_W-1:0]   cell_count_next;
    logic [CNT_W-1:0]   n;
    logic               cfg_wr;
    mem_req_t           p_req;
    mem_req_t           c_req;
    logic [ENTRY_W-1:0] p_rd_data;
    logic [ENTRY_W-1:0] c_rd_data;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    // Register write decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CELL_COUNT);
    assign cell_count_next = cfg_wr ? pwdata[CNT_W-1:0] : cell_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_count_reg <= '0;
        end else begin
            cell_count_reg <= cell_count_next;
        end
    end

    // Register read back
    assign prdata = (paddr == ADDR_CELL_COUNT) ? DATA_W'(cell_count_reg) : '0;

    // Cells in use, saturated to the table size
    assign n = (cell_count_reg > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : cell_count_reg;

    tdpa_store u_store (
        .aclk      (aclk),
        .p_req     (p_req),
        .c_req     (c_req),
        .p_rd_data (p_rd_data),
        .c_rd_data (c_rd_data)
    );

    tdpa_alu u_alu (
        .alu_req (alu_req),
        .alu_rsp (alu_rsp)
    );

    tdpa_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .n              (n),
        .cfg_wr         (cfg_wr),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_cell_index   (s_cell_index),
        .s_has_parent   (s_has_parent),
        .s_parent_index (s_parent_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_depth        (m_depth),
        .m_is_leaf      (m_is_leaf),
        .m_max_depth    (m_max_depth),
        .m_status       (m_status),
        .p_req          (p_req),
        .c_req          (c_req),
        .p_rd_data      (p_rd_data),
        .c_rd_data      (c_rd_data),
        .alu_req        (alu_req),
        .alu_rsp        (alu_rsp)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench for tree_depth_from_parent_array_top: parent table writes, depth/leaf
// queries and max-depth queries, checked against a shadow tree kept in a scoreboard.
// Depends on tdpa_pkg and the top-level RTL only.
module tb;
    import tdpa_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN  = 2'd3;
    localparam int unsigned RUN_LIMIT   = 2_000_000;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned DRAIN_CYCLES = 1100;
    localparam int unsigned WIDE_TABLE  = 64;

    typedef struct packed {
        logic [CELL_W-1:0] depth;
        logic              is_leaf;
        logic [CELL_W-1:0] max_depth;
        status_t           status;
    } answer_t;

    // Shadow of the parent table and child counts; queues one answer per request
    class tree_scoreboard;
        logic [ENTRY_W-1:0] parent_tab [MAX_CELLS];
        logic [CNT_W-1:0]   children [MAX_CELLS];
        logic [CNT_W-1:0]   count_reg;
        answer_t            pending_answers [$];
        int unsigned        errors;
        int unsigned        answers_checked;

        function new();
            foreach (parent_tab[k]) begin
                parent_tab[k] = '0;
                children[k]   = '0;
            end
            count_reg       = '0;
            errors          = 0;
            answers_checked = 0;
        endfunction

        function int unsigned cells_in_use();
            return (count_reg > MAX_CELLS) ? MAX_CELLS : int'(count_reg);
        endfunction

        // New count: keep entries, rebuild child counts over cells now in use
        function void update_cell_count(logic [CNT_W-1:0] v);
            int unsigned n;
            logic [CELL_W-1:0] p;
            count_reg = v;
            n = cells_in_use();
            foreach (children[k]) children[k] = '0;
            for (int unsigned i = 0; i < n; i++) begin
                p = parent_tab[i][CELL_W-1:0];
                if (parent_tab[i][CELL_W] && p < n) children[p] = children[p] + 1'b1;
            end
        endfunction

        // Follow parents to a root; stop on a stale parent or after n levels
        function status_t walk_chain(int unsigned start, int unsigned n,
                                     output int unsigned d);
            int unsigned at;
            int unsigned steps;
            at = start;
            steps = 0;
            d = 0;
            while (parent_tab[at][CELL_W]) begin
                at = parent_tab[at][CELL_W-1:0];
                if (at >= n) return ST_RANGE;
                steps++;
                if (steps >= n) return ST_CYCLE;
            end
            d = steps;
            return ST_OK;
        endfunction

        function void note_request(logic [1:0] kind, logic [CELL_W-1:0] idx, logic hp,
                                   logic [CELL_W-1:0] par);
            answer_t a;
            int unsigned n, d, dm;
            logic [ENTRY_W-1:0] old;
            a = '0;
            dm = 0;
            n = cells_in_use();
            case (kind)
                REQ_WRITE: begin
                    if (idx >= n || (hp && par >= n)) begin
                        a.status = ST_RANGE;
                    end else begin
                        old = parent_tab[idx];
                        if (old[CELL_W] && old[CELL_W-1:0] < n
                                && children[old[CELL_W-1:0]] != 0)
                            children[old[CELL_W-1:0]] = children[old[CELL_W-1:0]] - 1'b1;
                        if (hp) begin
                            parent_tab[idx] = {1'b1, par};
                            children[par]   = children[par] + 1'b1;
                        end else begin
                            parent_tab[idx] = '0;
                        end
                    end
                end
                REQ_CELL: begin
                    if (idx >= n) begin
                        a.status = ST_RANGE;
                    end else begin
                        a.status = walk_chain(idx, n, d);
                        if (a.status == ST_OK) begin
                            a.depth   = d[CELL_W-1:0];
                            a.is_leaf = (children[idx] == 0);
                        end
                    end
                end
                REQ_MAX: begin
                    // first failing cell in index order decides the status
                    for (int unsigned i = 0; i < n; i++) begin
                        a.status = walk_chain(i, n, d);
                        if (a.status != ST_OK) begin
                            dm = 0;
                            break;
                        end
                        if (d > dm) dm = d;
                    end
                    a.max_depth = dm[CELL_W-1:0];
                end
                default: a.status = ST_RANGE;
            endcase
            pending_answers.push_back(a);
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            if (errors < 100)
                $display("[%0t] result %0d: %s got %0h expected %0h",
                         $time, answers_checked, what, got, want);
            errors++;
        endtask

        task check_result(logic [CELL_W-1:0] depth, logic leaf, logic [CELL_W-1:0] maxd,
                          logic [1:0] st);
            answer_t want;
            answers_checked++;
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected beat, status", st, 'x);
                return;
            end
            want = pending_answers.pop_front();
            if (st !== want.status)       report_mismatch("status", st, want.status);
            if (depth !== want.depth)     report_mismatch("depth", depth, want.depth);
            if (leaf !== want.is_leaf)    report_mismatch("is_leaf", leaf, want.is_leaf);
            if (maxd !== want.max_depth)  report_mismatch("max_depth", maxd, want.max_depth);
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic s_valid, s_ready;
    logic [1:0] s_req_type;
    logic [CELL_W-1:0] s_cell_index;
    logic s_has_parent;
    logic [CELL_W-1:0] s_parent_index;
    logic m_valid, m_ready;
    logic [CELL_W-1:0] m_depth;
    logic m_is_leaf;
    logic [CELL_W-1:0] m_max_depth;
    logic [1:0] m_status;

    tree_scoreboard sb;
    int unsigned cycle_count;
    int unsigned stimulus_items;
    int unsigned burst_left;

    tree_depth_from_parent_array_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_cell_index   (s_cell_index),
        .s_has_parent   (s_has_parent),
        .s_parent_index (s_parent_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_depth        (m_depth),
        .m_is_leaf      (m_is_leaf),
        .m_max_depth    (m_max_depth),
        .m_status       (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one request beat; open a new burst after a random gap when the last one ran out
    task automatic send_request(logic [1:0] kind, logic [CELL_W-1:0] idx, logic hp,
                                logic [CELL_W-1:0] par);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_req_type     <= kind;
        s_cell_index   <= idx;
        s_has_parent   <= hp;
        s_parent_index <= par;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(kind, idx, hp, par);
        burst_left--;
        if (kind != REQ_UNKNOWN) stimulus_items++;
    endtask

    // Drain all answers, wait for the input to open, then write cell_count over APB
    task automatic set_cell_count(logic [CNT_W-1:0] v);
        s_valid <= 1'b0;
        while (sb.pending_answers.size() != 0) @(posedge aclk);
        do @(posedge aclk); while (!s_ready);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CELL_COUNT;
        pwdata  <= {{(DATA_W-CNT_W){1'b0}}, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.update_cell_count(v);
    endtask

    // Mostly well-formed forest writes and in-range queries, plus noise
    task automatic run_phase(int unsigned len);
        int unsigned n, pick;
        bit wide;
        logic [1:0] kind;
        logic [CELL_W-1:0] idx, par;
        logic hp;
        for (int unsigned k = 0; k < len; k++) begin
            n = sb.cells_in_use();
            wide = (n > WIDE_TABLE);
            pick = $urandom_range(0, 99);
            idx = (n != 0) ? CELL_W'($urandom_range(0, n - 1)) : CELL_W'($urandom);
            par = CELL_W'($urandom);
            hp = 1'b1;
            if (pick < 45) begin
                kind = REQ_WRITE;
                if (idx == 0 || $urandom_range(0, 6) == 0) hp = 1'b0;
                else par = CELL_W'($urandom_range(0, idx - 1));
            end else if (pick < 75 || (pick < 83 && wide)) begin
                kind = REQ_CELL;
                hp = 1'($urandom);
            end else if (pick < 83) begin
                kind = REQ_MAX;
                hp = 1'($urandom);
            end else if (pick < 93) begin
                kind = REQ_WRITE;
                idx = CELL_W'($urandom);
                hp = 1'($urandom);
            end else if (pick < 97) begin
                kind = REQ_CELL;
                idx = CELL_W'($urandom);
            end else begin
                kind = REQ_UNKNOWN;
                idx = CELL_W'($urandom);
                hp = 1'($urandom);
            end
            send_request(kind, idx, hp, par);
        end
    endtask

    // Check every result beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_depth, m_is_leaf, m_max_depth, m_status);
    end

    // Receiver: stall patterns in segments, plus a few long hold-offs to back up the input
    initial begin : result_sink
        int unsigned seg_left, mode, hold_left, next_hold_at, period, tick;
        seg_left = 0;
        mode = 0;
        hold_left = 0;
        next_hold_at = 150;
        period = 2;
        tick = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && sb.answers_checked >= next_hold_at) begin
                hold_left = 500;
                next_hold_at += 700;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 150);
                    period = $urandom_range(2, 6);
                end
                seg_left--;
                tick++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom);
                    2: m_ready <= ($urandom_range(0, 9) != 0);
                    default: m_ready <= (tick % period == 0);
                endcase
            end
        end
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int unsigned pick;
        logic [CNT_W-1:0] cnt;
        sb = new();
        stimulus_items = 0;
        burst_left = 0;
        aresetn        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        s_valid        <= 1'b0;
        s_req_type     <= '0;
        s_cell_index   <= '0;
        s_has_parent   <= 1'b0;
        s_parent_index <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table: everything out of range except the max query
        set_cell_count('0);
        send_request(REQ_WRITE, 10'd0, 1'b1, 10'd0);
        send_request(REQ_CELL, 10'd0, 1'b0, 10'd0);
        send_request(REQ_MAX, 10'd0, 1'b0, 10'd0);
        send_request(REQ_UNKNOWN, 10'h3FF, 1'b1, 10'h3FF);

        // Full table: all roots, then a self parent on the top cell
        set_cell_count(CNT_W'(MAX_CELLS));
        send_request(REQ_MAX, 10'd0, 1'b0, 10'd0);
        send_request(REQ_WRITE, 10'h3FF, 1'b1, 10'h3FF);
        send_request(REQ_CELL, 10'h3FF, 1'b0, 10'd0);
        send_request(REQ_MAX, 10'd0, 1'b0, 10'd0);
        send_request(REQ_WRITE, 10'h3FF, 1'b0, 10'd0);

        // Small tree: depth and leaf, range errors, self and two-cell cycles
        set_cell_count(11'd8);
        send_request(REQ_WRITE, 10'd1, 1'b1, 10'd0);
        send_request(REQ_WRITE, 10'd2, 1'b1, 10'd0);
        send_request(REQ_WRITE, 10'd3, 1'b1, 10'd1);
        send_request(REQ_WRITE, 10'd9, 1'b1, 10'd0);
        send_request(REQ_WRITE, 10'd3, 1'b1, 10'd9);
        send_request(REQ_CELL, 10'd3, 1'b0, 10'd0);
        send_request(REQ_CELL, 10'd9, 1'b0, 10'd0);
        send_request(REQ_MAX, 10'd0, 1'b0, 10'd0);
        send_request(REQ_WRITE, 10'd5, 1'b1, 10'd5);
        send_request(REQ_CELL, 10'd5, 1'b0, 10'd0);
        send_request(REQ_WRITE, 10'd6, 1'b1, 10'd7);
        send_request(REQ_WRITE, 10'd7, 1'b1, 10'd6);
        send_request(REQ_MAX, 10'd0, 1'b0, 10'd0);
        send_request(REQ_WRITE, 10'd5, 1'b0, 10'h3FF);
        send_request(REQ_WRITE, 10'd6, 1'b0, 10'd0);
        send_request(REQ_WRITE, 10'd2, 1'b1, 10'd6);

        // Shrink: cell 2 now names a stale parent
        set_cell_count(11'd4);
        send_request(REQ_CELL, 10'd2, 1'b0, 10'd0);
        send_request(REQ_MAX, 10'd0, 1'b0, 10'd0);
        send_request(REQ_CELL, 10'd1, 1'b0, 10'd0);

        // Oversized count saturates to the full table
        set_cell_count('1);
        send_request(REQ_CELL, 10'd2, 1'b0, 10'd0);
        send_request(REQ_MAX, 10'd0, 1'b0, 10'd0);

        // One chain through the whole table, reaching the deepest cell
        set_cell_count(CNT_W'(MAX_CELLS));
        for (int unsigned i = 1; i < MAX_CELLS; i++) begin
            send_request(REQ_WRITE, CELL_W'(i), 1'b1, CELL_W'(i - 1));
            if ($urandom_range(0, 15) == 0)
                send_request(REQ_CELL, CELL_W'($urandom_range(0, i)), 1'($urandom),
                             CELL_W'($urandom));
        end
        send_request(REQ_CELL, 10'h3FF, 1'b0, 10'd0);
        send_request(REQ_CELL, 10'd0, 1'b0, 10'd0);

        // Random phases, mostly small tables, a few full, oversized or wide ones
        while (stimulus_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                cnt = CNT_W'($urandom_range(0, 1));
            end else if (pick < 78) begin
                cnt = CNT_W'($urandom_range(2, 40));
            end else begin
                case ($urandom_range(0, 3))
                    0: cnt = CNT_W'(MAX_CELLS);
                    1: cnt = '1;
                    2: cnt = CNT_W'($urandom_range(MAX_CELLS + 1, 2046));
                    default: cnt = CNT_W'($urandom_range(WIDE_TABLE + 1, MAX_CELLS - 1));
                endcase
            end
            set_cell_count(cnt);
            run_phase($urandom_range(30, 120));
        end

        // Drain, then watch for stray beats
        s_valid <= 1'b0;
        while (sb.pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ----- files.f -----
src/tdpa_pkg.sv
src/tdpa_store.sv
src/tdpa_alu.sv
src/tdpa_ctrl.sv
src/tree_depth_from_parent_array_top.sv
bench/tb.sv
